// ===== rtl/ctes_pkg.sv =====
// ----------------------------------------------------------------------------
// ctes_pkg: constants for civil time to epoch seconds
// Calendar constants, reciprocal multipliers and the month offset table.
// ----------------------------------------------------------------------------
package ctes_pkg;

	// configuration register indexes
	localparam logic CfgStandard = 1'b0;
	localparam logic CfgDaylight = 1'b1;

	localparam int OffsetW = 18;

	localparam logic signed [11:0] YearBase     = 12'sd1900;
	localparam logic signed [17:0] SecsPerDay   = 18'sd86400;
	localparam logic signed [12:0] SecsPerHour  = 13'sd3600;
	localparam logic signed [7:0]  SecsPerMin   = 8'sd60;
	localparam logic signed [18:0] DaysPerEra   = 19'sd146097;
	localparam logic signed [20:0] EpochDayShift = 21'sd719468;

	// floor(m / 12) = floor(floor(m / 4) / 3); bias keeps the dividend positive
	localparam logic [31:0] Bias3   = 32'd805306368;   // 3 * 2^28
	localparam logic [31:0] Recip3  = 32'hAAAAAAAB;    // ceil(2^33 / 3)
	localparam logic signed [31:0] Bias3Q = 32'sd268435456;

	// floor(y / 400) = floor(floor(y / 16) / 25)
	localparam logic signed [29:0] Bias25  = 30'sd209715200;  // 25 * 2^23
	localparam logic [29:0]        Recip25 = 30'd687194768;    // ceil(2^34 / 25)
	localparam logic signed [25:0] Bias25Q = 26'sd8388608;

	// days from March 1 to the first of month mp (0 is March)
	function automatic logic [8:0] month_day_offset(input logic [3:0] mp);
		logic [8:0] d;
		case (mp)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/civil_time_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds
// Broken-down civil time to proleptic Gregorian seconds since 1970 UTC.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis_* (six 32-bit signed fields in tdata, the
//   2-bit signed DST flag in tuser). Each accepted word yields exactly one
//   output word on m_axis_*: 64-bit signed epoch seconds in tdata and the
//   failure flag in tuser (DST unknown while the two offsets differ; tdata
//   is then all ones).
//   The two UTC offsets are set on the cfg_* write port; write them only
//   while no word is in flight.
//   Six-stage pipeline: a word passes stages 1 to 6 in order and leaves
//   from the stage 6 register; throughput is one word per cycle while
//   the receiver does not stall. The depth is set by the two reciprocal
//   multiplies (month fold, 400-year era split) and the day/second scaling.
//   A stage holds its word while the next is full and stalled, so empty slots
//   close up; when the receiver stalls the pipe fills and s_axis_tready
//   drops once all six stages hold a word. Nothing is lost or repeated.
//   Reset clears all stage valid bits and both offsets to zero.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds
	import ctes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,

	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [17:0]  cfg_data,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// years_since_1900, month_index, day_of_month, hour_value, minute_value,
	// second_value (32 bits each, lowest first)
	input  logic [191:0] s_axis_tdata,
	// dst_flag
	input  logic [1:0]   s_axis_tuser,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// epoch_seconds
	output logic [63:0]  m_axis_tdata,
	// failed
	output logic         m_axis_tuser
);

	// offsets
	logic signed [OffsetW-1:0] std_off_q, dst_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			std_off_q <= '0;
			dst_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgStandard: std_off_q <= cfg_data;
				CfgDaylight: dst_off_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage enables: a stage loads when it is empty or the next one moves
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v6_s6 || m_axis_tready;
	assign en5 = !v5_s5 || en6;
	assign en4 = !v4_s4 || en5;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_axis_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en5) v5_s5 <= v4_s4;
			if (en6) v6_s6 <= v5_s5;
		end
	end

	// ---- stage 1: unpack, offset select, month / 12 reciprocal multiply
	logic signed [31:0] in_year, in_month, in_day, in_hour, in_min, in_sec;
	logic signed [1:0]  in_dst;
	logic signed [29:0] m_quart;
	logic [31:0]        m_biased;
	logic [63:0]        m_prod;

	assign in_year  = s_axis_tdata[31:0];
	assign in_month = s_axis_tdata[63:32];
	assign in_day   = s_axis_tdata[95:64];
	assign in_hour  = s_axis_tdata[127:96];
	assign in_min   = s_axis_tdata[159:128];
	assign in_sec   = s_axis_tdata[191:160];
	assign in_dst   = s_axis_tuser;

	assign m_quart  = in_month[31:2];          // floor(m / 4)
	assign m_biased = 32'(m_quart) + Bias3;
	assign m_prod   = 64'(m_biased) * 64'(Recip3);

	logic [30:0]               mq_hi_s1;
	logic [3:0]                mlo_s1;
	logic signed [32:0]        year1900_s1;
	logic signed [31:0]        day_s1, sec_s1;
	logic signed [44:0]        hm_s1;
	logic signed [OffsetW-1:0] off_s1;
	logic                      fail_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			mq_hi_s1    <= m_prod[63:33];
			mlo_s1      <= in_month[3:0];
			year1900_s1 <= 33'(in_year) + 33'(YearBase);
			day_s1      <= in_day;
			sec_s1      <= in_sec;
			hm_s1       <= 45'(in_hour) * 45'(SecsPerHour) + 45'(in_min) * 45'(SecsPerMin);
			off_s1      <= (in_dst == 2'sb01) ? dst_off_q : std_off_q;
			fail_s1     <= in_dst[1] && (std_off_q != dst_off_q);
		end
	end

	// ---- stage 2: fold month into year, March-based month, linear seconds
	logic signed [28:0] mq;
	logic [3:0]         mrem, mp;
	logic signed [33:0] year_full, y_adj;

	assign mq        = 29'($signed({1'b0, mq_hi_s1}) - Bias3Q);
	// m - 12 * mq modulo 16; 12 * mq = -4 * mq modulo 16
	assign mrem      = mlo_s1 + {mq[1:0], 2'b00};    // month_index mod 12
	assign year_full = 34'(year1900_s1) + 34'(mq);
	assign y_adj     = year_full - ((mrem <= 4'd1) ? 34'sd1 : 34'sd0);
	assign mp        = (mrem >= 4'd2) ? mrem - 4'd2 : mrem + 4'd10;

	logic signed [33:0] y_s2;
	logic [8:0]         doy_s2;
	logic signed [51:0] lin_s2;
	logic               fail_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			y_s2    <= y_adj;
			doy_s2  <= month_day_offset(mp);
			lin_s2  <= (52'(day_s1) - 52'sd1) * 52'(SecsPerDay) + 52'(hm_s1)
			         + 52'(sec_s1) - 52'(off_s1);
			fail_s2 <= fail_s1;
		end
	end

	// ---- stage 3: year / 400 reciprocal multiply
	logic signed [29:0] y_div16;
	logic [28:0]        y_biased;
	logic [58:0]        y_prod;

	assign y_div16  = y_s2[33:4];
	assign y_biased = 29'(y_div16 + Bias25);
	assign y_prod   = 59'(y_biased) * 59'(Recip25);

	logic [24:0]        eq_s3;
	logic [8:0]         ylo_s3, doy_s3;
	logic signed [51:0] lin_s3;
	logic               fail_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			eq_s3   <= y_prod[58:34];
			ylo_s3  <= y_s2[8:0];
			doy_s3  <= doy_s2;
			lin_s3  <= lin_s2;
			fail_s3 <= fail_s2;
		end
	end

	// ---- stage 4: era, year of era, day of era
	logic signed [24:0] era;
	logic [8:0]         yoe;
	logic [1:0]         cent;
	logic [17:0]        doe;

	assign era  = 25'($signed({1'b0, eq_s3}) - Bias25Q);
	// yoe is 0..399, so the low nine bits of y - 400 * era are exact
	assign yoe  = ylo_s3 - 9'(era[8:0] * 9'd400);
	assign cent = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
	assign doe  = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(cent) + 18'(doy_s3);

	logic signed [24:0] era_s4;
	logic [17:0]        doe_s4;
	logic signed [51:0] lin_s4;
	logic               fail_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			era_s4  <= era;
			doe_s4  <= doe;
			lin_s4  <= lin_s3;
			fail_s4 <= fail_s3;
		end
	end

	// ---- stage 5: days since the epoch
	logic signed [43:0] days_s5;
	logic signed [51:0] lin_s5;
	logic               fail_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			days_s5 <= 44'(era_s4) * 44'(DaysPerEra) + 44'($signed({1'b0, doe_s4}))
			         - 44'(EpochDayShift);
			lin_s5  <= lin_s4;
			fail_s5 <= fail_s4;
		end
	end

	// ---- stage 6: seconds, failure override, output register
	logic [63:0] secs_s6;
	logic        fail_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			secs_s6 <= fail_s5 ? '1
			         : 64'(64'(days_s5) * 64'(SecsPerDay) + 64'(lin_s5));
			fail_s6 <= fail_s5;
		end
	end

	assign m_axis_tvalid = v6_s6;
	assign m_axis_tdata  = secs_s6;
	assign m_axis_tuser  = fail_s6;

	// ---- assertions
	// a failed word always carries all ones
	a_fail_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '1)
		else $error("failed word without all-ones seconds");

	// input back-pressure only comes from a full pipe behind a stalled output
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while pipeline can advance");

	// a word held at the output stays put until taken
	a_stage6_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v5_s5 && v6_s6 && !m_axis_tready |=> v6_s6 && v5_s5)
		else $error("pipeline dropped a word under stall");

endmodule
